### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BAT_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define BAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/bat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bat_pkg;

    localparam int unsigned SLOTS_DEF     = 128;
    localparam int unsigned ADDR_BITS_DEF = 64;
    localparam int unsigned FUNC_W        = 3;
    localparam int unsigned ADDR_W        = 64;
    localparam int unsigned COUNT_W       = 32;
    localparam int unsigned SLOT_W        = 7;
    localparam int unsigned STATUS_W      = 2;

    localparam logic [FUNC_W-1:0] FN_SET      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEL      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FIND     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET_TEMP = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_TEMP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_SET = 2'd3;

    localparam logic signed [COUNT_W-1:0] CNT_DEFAULT_CODE = -32'sd1;
    localparam logic signed [COUNT_W-1:0] CNT_ONE          = 32'sd1;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [ADDR_W-1:0]         address;
        logic signed [COUNT_W-1:0] skip_count;
        logic [SLOT_W-1:0]         slot_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      hit;
        logic [SLOT_W-1:0]         slot_out;
        logic signed [COUNT_W-1:0] count_out;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAKE,
        S_POP,
        S_WRITE,
        S_WAIT,
        S_REPLY
    } t_state;

endpackage

`default_nettype wire

### rtl/breakpoint_address_table.sv
// channel   | signals                    | beat taken when
// ----------+----------------------------+-------------------------------
// request   | start, busy, i_req         | start high while busy low
// result    | o_strobe, o_rsp            | every cycle o_strobe is high
//
// set, delete and find walk the slots through one address comparator until a match,
// one slot a cycle off the address memory read port; set temporary takes a slot (popping
// a freed one first) and writes it, delete temporary waits and replies, a bad slot or code
// is answered from idle; one request at a time; busy stays high until the result is registered
// reset is synchronous, active low, and clears the slot flags and free-list pointers
// the result strobe lasts one cycle and cannot be held off by the receiver
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_address_table #(
    parameter int unsigned SLOTS     = bat_pkg::SLOTS_DEF,
    parameter int unsigned ADDR_BITS = bat_pkg::ADDR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bat_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output bat_pkg::t_rsp o_rsp
);
    import bat_pkg::*;

    localparam int unsigned SW = $clog2(SLOTS);
    localparam int unsigned SC = SW + 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
    localparam logic [SC-1:0] FULL_CNT = SC'(SLOTS);

    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_rsp   r_rsp, n_rsp;
    logic   r_strobe, n_strobe;

    logic [SW-1:0]    r_idx, n_idx;
    logic             r_issue, n_issue;
    logic             r_cmp_vld, n_cmp_vld;
    logic [SW-1:0]    r_cmp_idx, n_cmp_idx;
    logic [SW-1:0]    r_slot, n_slot;
    logic [SLOTS-1:0] r_listed, n_listed;
    logic [SLOTS-1:0] r_temp, n_temp;
    logic [SC-1:0]    r_free_top, n_free_top;
    logic [SC-1:0]    r_next_fresh, n_next_fresh;

    logic                      a_we;
    logic [ADDR_BITS-1:0]      a_rdata;
    logic                      c_we;
    logic signed [COUNT_W-1:0] c_wdata;
    logic [COUNT_W-1:0]        c_rdata;
    logic                      s_we;
    logic [SW-1:0]             s_raddr;
    logic [SW-1:0]             s_rdata;

    logic          match;
    logic          scan_last;
    logic          del_temp_ok;
    logic [SW-1:0] in_slot;

    bat_ram #(.WIDTH(ADDR_BITS), .DEPTH(SLOTS)) u_addr_ram (
        .i_clk  (i_clk),
        .i_we   (a_we),
        .i_waddr(r_slot),
        .i_wdata(ADDR_BITS'(r_req.address)),
        .i_raddr(r_idx),
        .o_rdata(a_rdata)
    );

    bat_ram #(.WIDTH(COUNT_W), .DEPTH(SLOTS)) u_count_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(r_slot),
        .i_wdata(c_wdata),
        .i_raddr(r_slot),
        .o_rdata(c_rdata)
    );

    bat_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(r_free_top[SW-1:0]),
        .i_wdata(r_slot),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    assign s_raddr     = SW'(r_free_top - 1'b1);
    assign match       = r_cmp_vld && r_listed[r_cmp_idx]
                         && (a_rdata == ADDR_BITS'(r_req.address));
    assign scan_last   = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign in_slot     = SW'(i_req.slot_in);
    assign del_temp_ok = (32'(i_req.slot_in) < SLOTS) && r_temp[in_slot];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req.func)
                        FN_SET, FN_DEL, FN_FIND: n_state = S_SCAN;
                        FN_SET_TEMP:             n_state = S_TAKE;
                        FN_DEL_TEMP:             n_state = del_temp_ok ? S_WAIT : S_IDLE;
                        default:                 n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = S_WAIT;
                end else if (scan_last) begin
                    n_state = (r_req.func == FN_SET) ? S_TAKE : S_IDLE;
                end
            end
            S_TAKE: begin
                if (r_free_top != '0) begin
                    n_state = S_POP;
                end else if (r_next_fresh == FULL_CNT) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_POP:   n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            S_WAIT:  n_state = S_REPLY;
            S_REPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_req        = r_req;
        n_rsp        = r_rsp;
        n_strobe     = 1'b0;
        n_idx        = r_idx;
        n_issue      = r_issue;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_slot       = r_slot;
        n_listed     = r_listed;
        n_temp       = r_temp;
        n_free_top   = r_free_top;
        n_next_fresh = r_next_fresh;
        a_we         = 1'b0;
        c_we         = 1'b0;
        s_we         = 1'b0;
        c_wdata      = CNT_ONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req     = i_req;
                    n_idx     = '0;
                    n_issue   = 1'b1;
                    n_slot    = in_slot;
                    case (i_req.func)
                        FN_SET, FN_DEL, FN_FIND, FN_SET_TEMP: begin
                        end
                        FN_DEL_TEMP: begin
                            if (!del_temp_ok) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{ST_NOT_SET, 1'b0, '0, '0};
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_rsp    = '{ST_NOT_SET, 1'b0, '0, '0};
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // the read of slot r_idx is compared in the next cycle
                n_cmp_vld = r_issue;
                n_cmp_idx = r_idx;
                if (r_issue) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (match) begin
                    n_slot = r_cmp_idx;
                end else if (scan_last && (r_req.func != FN_SET)) begin
                    n_strobe = 1'b1;
                    n_rsp    = '{ST_NOT_SET, 1'b0, '0, '0};
                end
            end
            S_TAKE: begin
                if (r_free_top != '0) begin
                    n_free_top = r_free_top - 1'b1;
                end else if (r_next_fresh == FULL_CNT) begin
                    n_strobe = 1'b1;
                    n_rsp    = '{ST_FULL, 1'b0, '0, '0};
                end else begin
                    n_slot       = r_next_fresh[SW-1:0];
                    n_next_fresh = r_next_fresh + 1'b1;
                end
            end
            S_POP: begin
                n_slot = s_rdata;
            end
            S_WRITE: begin
                a_we = 1'b1;
                c_we = 1'b1;
                if (r_req.func == FN_SET && r_req.skip_count != CNT_DEFAULT_CODE) begin
                    c_wdata = r_req.skip_count;
                end
                n_listed[r_slot] = (r_req.func == FN_SET);
                n_temp[r_slot]   = (r_req.func == FN_SET_TEMP);
                n_strobe = 1'b1;
                n_rsp    = '{ST_OK, 1'b0, SLOT_W'(r_slot), c_wdata};
            end
            S_WAIT: begin
                // freeing happens while the count read is in flight
                if (r_req.func == FN_DEL || r_req.func == FN_DEL_TEMP) begin
                    if (r_req.func == FN_DEL) begin
                        n_listed[r_slot] = 1'b0;
                    end else begin
                        n_temp[r_slot] = 1'b0;
                    end
                    if (r_free_top < FULL_CNT) begin
                        s_we       = 1'b1;
                        n_free_top = r_free_top + 1'b1;
                    end
                end
            end
            S_REPLY: begin
                n_strobe = 1'b1;
                n_rsp    = '{(r_req.func == FN_SET) ? ST_ALREADY : ST_OK,
                             r_req.func == FN_FIND, SLOT_W'(r_slot), c_rdata};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_issue      <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_listed     <= '0;
            r_temp       <= '0;
            r_free_top   <= '0;
            r_next_fresh <= '0;
        end else begin
            r_state      <= n_state;
            r_strobe     <= n_strobe;
            r_issue      <= n_issue;
            r_cmp_vld    <= n_cmp_vld;
            r_listed     <= n_listed;
            r_temp       <= n_temp;
            r_free_top   <= n_free_top;
            r_next_fresh <= n_next_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rsp     <= n_rsp;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

`include "assert_macros.svh"

    // the free list only ever holds slots handed out earlier
    `BAT_ASSERT(a_free_le_fresh, i_clk, i_rst_n, 1'b1, r_free_top <= r_next_fresh)
    `BAT_ASSERT(a_fresh_bound, i_clk, i_rst_n, 1'b1, r_next_fresh <= FULL_CNT)
    // a slot being filled must not be in use
    `BAT_ASSERT(a_write_free_slot, i_clk, i_rst_n, r_state == S_WRITE,
        !r_listed[r_slot] && !r_temp[r_slot])
    `BAT_ASSERT_NEXT(a_strobe_idle, i_clk, i_rst_n, n_strobe, r_state == S_IDLE)

endmodule

`default_nettype wire

### rtl/bat_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bat_ram #(
    parameter int unsigned WIDTH = bat_pkg::COUNT_W,
    parameter int unsigned DEPTH = bat_pkg::SLOTS_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### tb/breakpoint_address_table_tb.sv
`timescale 1ns / 1ps

module breakpoint_address_table_tb;
    import bat_pkg::*;

    localparam int unsigned NSLOTS        = SLOTS_DEF;
    localparam int unsigned POOL_SIZE     = 160;
    localparam int unsigned RANDOM_ITEMS  = 1425;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned REPORT_MAX    = 30;
    localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNUSED_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_strobe;
    t_rsp  o_rsp;

    breakpoint_address_table uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the slot table
    logic [ADDR_W-1:0]         bp_addr    [NSLOTS];
    logic signed [COUNT_W-1:0] bp_count   [NSLOTS];
    bit                        bp_listed  [NSLOTS];
    bit                        bp_temp    [NSLOTS];
    logic [SLOT_W-1:0]         free_lifo  [NSLOTS];
    int                        free_depth;
    int                        fresh_next;

    t_req pending_req [$];
    t_rsp expected_rsp [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int   queued_cnt;
    int   accepted_cnt;
    int   error_cnt;
    int   gap_left;
    bit   no_gaps;
    int   idle_cycles;
    int   status_seen [4];
    int   hit_cnt;
    t_rsp oldest_rsp;

    task automatic clear_model();
        for (int k = 0; k < NSLOTS; k++) begin
            bp_addr[k]   = '0;
            bp_count[k]  = '0;
            bp_listed[k] = 1'b0;
            bp_temp[k]   = 1'b0;
            free_lifo[k] = '0;
        end
        free_depth = 0;
        fresh_next = 0;
    endtask

    function automatic int find_listed(logic [ADDR_W-1:0] addr);
        for (int k = 0; k < NSLOTS; k++)
            if (bp_listed[k] && bp_addr[k] == addr)
                return k;
        return -1;
    endfunction

    // freed slots first, newest first, then never-used ones
    function automatic int grab_slot();
        int s;
        if (free_depth > 0) begin
            free_depth--;
            return int'(free_lifo[free_depth]) % NSLOTS;
        end
        if (fresh_next >= NSLOTS)
            return -1;
        s = fresh_next;
        fresh_next++;
        return s;
    endfunction

    function automatic void release_slot(int s);
        if (free_depth < NSLOTS) begin
            free_lifo[free_depth] = SLOT_W'(s);
            free_depth++;
        end
    endfunction

    function automatic t_rsp predict_rsp(t_req r);
        t_rsp rsp;
        int   s;
        logic signed [COUNT_W-1:0] cnt;
        rsp = '0;
        rsp.status = ST_NOT_SET;
        case (r.func)
            FN_SET: begin
                s = find_listed(r.address);
                if (s >= 0) begin
                    rsp.status    = ST_ALREADY;
                    rsp.slot_out  = SLOT_W'(s);
                    rsp.count_out = bp_count[s];
                end else begin
                    s = grab_slot();
                    if (s < 0) begin
                        rsp.status = ST_FULL;
                    end else begin
                        cnt = (r.skip_count == CNT_DEFAULT_CODE) ? CNT_ONE : r.skip_count;
                        bp_addr[s]    = r.address;
                        bp_count[s]   = cnt;
                        bp_listed[s]  = 1'b1;
                        bp_temp[s]    = 1'b0;
                        rsp.status    = ST_OK;
                        rsp.slot_out  = SLOT_W'(s);
                        rsp.count_out = cnt;
                    end
                end
            end
            FN_DEL: begin
                s = find_listed(r.address);
                if (s >= 0) begin
                    bp_listed[s] = 1'b0;
                    release_slot(s);
                    rsp.status    = ST_OK;
                    rsp.slot_out  = SLOT_W'(s);
                    rsp.count_out = bp_count[s];
                end
            end
            FN_FIND: begin
                s = find_listed(r.address);
                if (s >= 0) begin
                    rsp.status    = ST_OK;
                    rsp.hit       = 1'b1;
                    rsp.slot_out  = SLOT_W'(s);
                    rsp.count_out = bp_count[s];
                end
            end
            FN_SET_TEMP: begin
                s = grab_slot();
                if (s < 0) begin
                    rsp.status = ST_FULL;
                end else begin
                    bp_addr[s]    = r.address;
                    bp_count[s]   = CNT_ONE;
                    bp_listed[s]  = 1'b0;
                    bp_temp[s]    = 1'b1;
                    rsp.status    = ST_OK;
                    rsp.slot_out  = SLOT_W'(s);
                    rsp.count_out = CNT_ONE;
                end
            end
            FN_DEL_TEMP: begin
                s = int'(r.slot_in);
                if (s < NSLOTS && bp_temp[s]) begin
                    bp_temp[s] = 1'b0;
                    release_slot(s);
                    rsp.status    = ST_OK;
                    rsp.slot_out  = SLOT_W'(s);
                    rsp.count_out = bp_count[s];
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic add_req(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr,
                           logic signed [COUNT_W-1:0] cnt, logic [SLOT_W-1:0] slot);
        t_req r;
        r.func       = fn;
        r.address    = addr;
        r.skip_count = cnt;
        r.slot_in    = slot;
        pending_req.push_back(r);
        queued_cnt++;
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [COUNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 20) return CNT_DEFAULT_CODE;
        if (r < 24) return 32'sh7fffffff;
        if (r < 28) return 32'sh80000000;
        if (r < 31) return '0;
        if (r < 34) return -32'sd2;
        return $urandom;
    endfunction

    // mostly a slot that is temporary right now, so deletes land
    function automatic logic [SLOT_W-1:0] pick_temp_slot();
        int base;
        base = $urandom_range(NSLOTS - 1);
        if ($urandom_range(3) != 0)
            for (int k = 0; k < NSLOTS; k++)
                if (bp_temp[(base + k) % NSLOTS])
                    return SLOT_W'((base + k) % NSLOTS);
        return SLOT_W'(base);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_listed_addr();
        int base;
        base = $urandom_range(NSLOTS - 1);
        for (int k = 0; k < NSLOTS; k++)
            if (bp_listed[(base + k) % NSLOTS])
                return bp_addr[(base + k) % NSLOTS];
        return addr_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic add_random(bit filling);
        int r;
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slot;
        r    = $urandom_range(99);
        addr = ($urandom_range(9) == 0) ? rand_addr() : addr_pool[$urandom_range(POOL_SIZE - 1)];
        slot = SLOT_W'($urandom_range(NSLOTS - 1));
        if (filling) begin
            if (r < 45)      fn = FN_SET;
            else if (r < 65) fn = FN_SET_TEMP;
            else if (r < 77) fn = FN_FIND;
            else if (r < 87) fn = FN_DEL;
            else if (r < 95) fn = FN_DEL_TEMP;
            else             fn = FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
        end else begin
            if (r < 8)       fn = FN_SET;
            else if (r < 12) fn = FN_SET_TEMP;
            else if (r < 27) fn = FN_FIND;
            else if (r < 67) fn = FN_DEL;
            else if (r < 95) fn = FN_DEL_TEMP;
            else             fn = FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
        end
        if ((fn == FN_DEL || fn == FN_FIND) && $urandom_range(9) < 6)
            addr = pick_listed_addr();
        if (fn == FN_DEL_TEMP)
            slot = pick_temp_slot();
        add_req(fn, addr, rand_count(), slot);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: a beat is taken when start is high and busy is low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                expected_rsp.push_back(predict_rsp(i_req));
                accepted_cnt++;
            end
            if (start && busy) begin
                // hold the beat until the block is free
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_req.size() > 0) begin
                i_req <= pending_req.pop_front();
                start <= 1'b1;
                if ($urandom_range(59) == 0)
                    no_gaps = !no_gaps;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobe is a result beat
    // fields shown as status/hit/slot/count
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_rsp.size() == 0) begin
                error_cnt++;
                if (error_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result beat %0d/%0d/%0d/%0d",
                             $time, o_rsp.status, o_rsp.hit, o_rsp.slot_out, o_rsp.count_out);
            end else begin
                oldest_rsp = expected_rsp.pop_front();
                if (o_rsp.status !== oldest_rsp.status || o_rsp.hit !== oldest_rsp.hit
                        || o_rsp.slot_out !== oldest_rsp.slot_out
                        || o_rsp.count_out !== oldest_rsp.count_out) begin
                    error_cnt++;
                    if (error_cnt <= REPORT_MAX)
                        $display("%0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $time, oldest_rsp.status, oldest_rsp.hit, oldest_rsp.slot_out,
                                 oldest_rsp.count_out, o_rsp.status, o_rsp.hit, o_rsp.slot_out,
                                 o_rsp.count_out);
                end else begin
                    status_seen[oldest_rsp.status]++;
                    if (oldest_rsp.hit)
                        hit_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("breakpoint_address_table: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] temp_addr;
        bit filling;
        int phase_left;
        int made;
        queued_cnt   = 0;
        accepted_cnt = 0;
        error_cnt    = 0;
        idle_cycles  = 0;
        hit_cnt      = 0;
        gap_left     = 0;
        no_gaps      = 1'b0;
        for (int k = 0; k < 4; k++)
            status_seen[k] = 0;
        clear_model();

        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            // some neighbours one bit apart to stress the compare
            addr_pool[k] = ($urandom_range(3) == 0)
                ? addr_pool[k - 1] ^ (64'd1 << $urandom_range(ADDR_W - 1)) : rand_addr();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        temp_addr = rand_addr();
        add_req(FN_SET,      '0,              CNT_DEFAULT_CODE, '0);
        add_req(FN_SET,      '1,              32'sh7fffffff,    '1);
        add_req(FN_SET,      '0,              32'sd5,           '0);
        add_req(FN_FIND,     '1,              '0,               '0);
        add_req(FN_FIND,     64'h1234,        '0,               '0);
        add_req(FN_SET_TEMP, temp_addr,       32'sd9,           '0);
        add_req(FN_DEL_TEMP, 64'h55,          '0,               7'd2);
        add_req(FN_DEL_TEMP, '0,              '0,               7'd2);
        add_req(FN_DEL_TEMP, '0,              '0,               7'd127);
        add_req(FN_DEL,      '0,              '0,               '0);
        add_req(FN_DEL,      '0,              '0,               '0);
        add_req(FN_SET,      64'h8000_0000_0000_0000, 32'sh80000000, '0);
        add_req(FN_SET_TEMP, temp_addr,       CNT_DEFAULT_CODE, '1);
        add_req(FN_FIND,     temp_addr,       '0,               '0);
        add_req(FN_SET,      temp_addr,       '0,               '0);
        add_req(FN_UNUSED_FIRST, '1,          '1,               '1);
        add_req(FN_UNUSED_MID, '0,            '0,               '0);
        add_req(FN_UNUSED_LAST, 64'h8000_0000_0000_0000, 32'sd1, 7'd3);
        add_req(FN_SET,      64'hdead_beef,   -32'sd2,          '0);
        add_req(FN_FIND,     64'h8000_0000_0000_0000, '0,       '0);
        add_req(FN_DEL_TEMP, '0,              '0,               7'd1);
        add_req(FN_DEL,      temp_addr,       '0,               '0);
        add_req(FN_DEL_TEMP, '0,              '0,               7'd2);

        // alternate long filling stretches with draining ones
        filling    = 1'b1;
        phase_left = $urandom_range(200, 320);
        made       = 0;
        while (made < RANDOM_ITEMS) begin
            while (pending_req.size() >= 2)
                @(posedge i_clk);
            add_random(filling);
            made++;
            phase_left--;
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = filling ? $urandom_range(200, 320) : $urandom_range(150, 260);
            end
        end

        while (accepted_cnt < queued_cnt || expected_rsp.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d ok (%0d find hits), %0d already set,",
                 accepted_cnt, status_seen[ST_OK], hit_cnt, status_seen[ST_ALREADY]);
        $display("%0d table full, %0d not set, %0d bad results",
                 status_seen[ST_FULL], status_seen[ST_NOT_SET], error_cnt);
        if (error_cnt == 0)
            $display("breakpoint_address_table: match");
        else
            $display("breakpoint_address_table: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/bat_pkg.sv
rtl/bat_ram.sv
rtl/breakpoint_address_table.sv
tb/breakpoint_address_table_tb.sv
